// ----- design/sdc_pkg.sv -----
`timescale 1ns / 1ps

package sdc_pkg;

	// field widths fixed by the sample and result formats
	localparam int SAMPLE_W = 32;
	localparam int TIME_W   = 32;
	localparam int DEV_W    = 31;
	localparam int DT_W     = 31;

	// deviation after reset: 1.0 in Q15.16
	localparam logic [DEV_W-1:0] DEV_RESET = 31'd65536;

	// one input transaction
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_value;
		logic        [TIME_W-1:0]   sample_time;
	} sample_t;

	// one output transaction
	typedef struct packed {
		logic       archive;
		logic [1:0] decision;
	} result_t;

	// reason codes carried in result decision
	typedef enum logic [1:0] {
		DEC_INSIDE      = 2'd0,
		DEC_FIRST       = 2'd1,
		DEC_OUTSIDE     = 2'd2,
		DEC_NO_PROGRESS = 2'd3
	} dec_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV_A,
		ST_DIV_B,
		ST_DECIDE,
		ST_OUT
	} seq_state_t;

endpackage

// ----- design/sdc_divider.sv -----
`timescale 1ns / 1ps

module sdc_divider import sdc_pkg::*; #(
	parameter int NUM_W = 35
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [NUM_W-1:0] num,
	input  logic        [DT_W-1:0]  den,
	output logic                    done,
	output logic signed [NUM_W-1:0] quo_floor,
	output logic signed [NUM_W-1:0] quo_ceil
);

	localparam int MAG_W = NUM_W - 1;
	localparam int CNT_W = $clog2(MAG_W + 1);

	logic                 busy_q;
	logic                 done_q;
	logic                 neg_q;
	logic [MAG_W-1:0]     mag_q;
	logic [DT_W-1:0]      rem_q;
	logic [DT_W-1:0]      den_q;
	logic [CNT_W-1:0]     cnt_q;

	logic signed [NUM_W-1:0] num_abs;
	logic [DT_W:0]           rem_sh;
	logic [DT_W+1:0]         trial;
	logic                    fits;
	logic signed [NUM_W-1:0] q_pos;
	logic signed [NUM_W-1:0] rem_nz;

	// magnitude of the numerator, known to stay below 2^(NUM_W-1)
	assign num_abs = num[NUM_W-1] ? -num : num;

	// one restoring step: shift in the next dividend bit and try a subtract
	assign rem_sh = {rem_q, mag_q[MAG_W-1]};
	assign trial  = {1'b0, rem_sh} - {2'b00, den_q};
	assign fits   = !trial[DT_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(MAG_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operand and partial remainder registers
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			neg_q <= num[NUM_W-1];
			mag_q <= num_abs[MAG_W-1:0];
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? trial[DT_W-1:0] : rem_sh[DT_W-1:0];
			mag_q <= {mag_q[MAG_W-2:0], fits};
		end
	end

	// signed floor and ceiling from magnitude quotient and remainder
	assign q_pos  = NUM_W'(mag_q);
	assign rem_nz = NUM_W'(|rem_q);

	always_comb begin
		if (neg_q) begin
			quo_floor = -q_pos - rem_nz;
			quo_ceil  = -q_pos;
		end else begin
			quo_floor = q_pos;
			quo_ceil  = q_pos + rem_nz;
		end
	end

	assign done = done_q;

endmodule

// ----- design/swinging_door_compressor.sv -----
`timescale 1ns / 1ps

// channel   direction  handshake                    payload
// sample    in         sample_valid / sample_stall  sample (sample_value, sample_time)
// result    out        result_valid / result_stall  result (archive, decision)
// config    in         cfg_wr_en                    cfg_wr_data (deviation)
//
// One sample at a time. A first or non-advancing sample goes from ST_CHECK straight
// to ST_OUT. Any other sample runs two divisions by the elapsed ticks on one
// shared radix-2 divider, one quotient bit per cycle, then passes ST_DECIDE
// on its way to ST_OUT.
// Reset clears the sequencer, the output valid flag and the door state at once, and restores the deviation.
// The next sample is taken while a finished result still waits on result_stall.

module swinging_door_compressor import sdc_pkg::*; #(
	parameter int VALUE_BITS = 32,
	parameter int SLOPE_BITS = 40
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_stall,
	input  sample_t          sample,
	output logic             result_valid,
	input  logic             result_stall,
	output result_t          result,
	input  logic             cfg_wr_en,
	input  logic [DEV_W-1:0] cfg_wr_data
);

	localparam int EXT_W = (VALUE_BITS > SAMPLE_W) ? VALUE_BITS : SAMPLE_W;
	localparam int NUM_W = ((VALUE_BITS > DEV_W) ? VALUE_BITS : DEV_W) + 3;
	localparam int CMP_W = (NUM_W > SLOPE_BITS) ? NUM_W : SLOPE_BITS;

	localparam logic signed [EXT_W-1:0] V_MAX =
		{{(EXT_W - VALUE_BITS + 1){1'b0}}, {(VALUE_BITS - 1){1'b1}}};
	localparam logic signed [EXT_W-1:0] V_MIN = ~V_MAX;
	localparam logic signed [CMP_W-1:0] S_MAX =
		{{(CMP_W - SLOPE_BITS + 1){1'b0}}, {(SLOPE_BITS - 1){1'b1}}};
	localparam logic signed [CMP_W-1:0] S_MIN = ~S_MAX;
	localparam logic signed [SLOPE_BITS-1:0] DOOR_UP = {1'b0, {(SLOPE_BITS - 1){1'b1}}};
	localparam logic signed [SLOPE_BITS-1:0] DOOR_LO = {1'b1, {(SLOPE_BITS - 1){1'b0}}};

	seq_state_t state_q, state_d;

	logic [DEV_W-1:0]             dev_q;
	logic signed [VALUE_BITS-1:0] anchor_value_q;
	logic [TIME_W-1:0]            anchor_time_q;
	logic signed [SLOPE_BITS-1:0] upper_q;
	logic signed [SLOPE_BITS-1:0] lower_q;
	logic                         started_q;

	logic signed [VALUE_BITS-1:0] v_q;
	logic [TIME_W-1:0]            t_q;
	logic [DT_W-1:0]              dt_q;
	logic signed [NUM_W-1:0]      fa_q, ca_q, fb_q, cb_q;
	result_t                      res_q;
	logic                         out_valid_q;
	result_t                      out_q;

	logic signed [EXT_W-1:0]      s_ext;
	logic signed [VALUE_BITS-1:0] v_sat;
	logic [TIME_W-1:0]            dt_full;
	logic                         no_prog;
	logic signed [NUM_W-1:0]      v_n, anc_n, dev_n, num_a, num_b;
	logic                         div_start, div_done;
	logic signed [NUM_W-1:0]      div_num, div_floor, div_ceil;
	logic [DT_W-1:0]              div_den;
	logic signed [CMP_W-1:0]      cb_c, fa_c, ca_c, fb_c, up_c, lo_c, nu_c, nl_c;
	logic signed [SLOPE_BITS-1:0] nu, nl;
	logic                         outside;
	logic                         load_out;

	// saturate incoming sample to the value width
	always_comb begin
		s_ext = EXT_W'(sample.sample_value);
		if (s_ext > V_MAX) begin
			v_sat = V_MAX[VALUE_BITS-1:0];
		end else if (s_ext < V_MIN) begin
			v_sat = V_MIN[VALUE_BITS-1:0];
		end else begin
			v_sat = s_ext[VALUE_BITS-1:0];
		end
	end

	// elapsed ticks and the two division numerators
	assign dt_full = t_q - anchor_time_q;
	assign no_prog = (dt_full == '0) || dt_full[TIME_W-1];
	assign v_n     = NUM_W'(v_q);
	assign anc_n   = NUM_W'(anchor_value_q);
	assign dev_n   = NUM_W'(dev_q);
	assign num_a   = v_n - anc_n + dev_n;
	assign num_b   = v_n - anc_n - dev_n;

	assign div_num = (state_q == ST_CHECK) ? num_a : num_b;
	assign div_den = (state_q == ST_CHECK) ? dt_full[DT_W-1:0] : dt_q;

	sdc_divider #(
		.NUM_W (NUM_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.num       (div_num),
		.den       (div_den),
		.done      (div_done),
		.quo_floor (div_floor),
		.quo_ceil  (div_ceil)
	);

	// corridor test and door candidates, saturated to the slope width
	always_comb begin
		cb_c = CMP_W'(cb_q);
		fa_c = CMP_W'(fa_q);
		ca_c = CMP_W'(ca_q);
		fb_c = CMP_W'(fb_q);
		up_c = CMP_W'(upper_q);
		lo_c = CMP_W'(lower_q);
		outside = (cb_c > up_c) || (fa_c < lo_c);
		nu_c = (ca_c > S_MAX) ? S_MAX : ((ca_c < S_MIN) ? S_MIN : ca_c);
		nl_c = (fb_c > S_MAX) ? S_MAX : ((fb_c < S_MIN) ? S_MIN : fb_c);
		nu   = nu_c[SLOPE_BITS-1:0];
		nl   = nl_c[SLOPE_BITS-1:0];
	end

	// sequencer next state and strobes
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (sample_valid) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (!started_q || no_prog) begin
					state_d = ST_OUT;
				end else begin
					div_start = 1'b1;
					state_d   = ST_DIV_A;
				end
			end
			ST_DIV_A: begin
				if (div_done) begin
					div_start = 1'b1;
					state_d   = ST_DIV_B;
				end
			end
			ST_DIV_B: begin
				if (div_done) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || !result_stall) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration, door state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_q          <= DEV_RESET;
			anchor_value_q <= '0;
			anchor_time_q  <= '0;
			upper_q        <= DOOR_UP;
			lower_q        <= DOOR_LO;
			started_q      <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_wr_en) dev_q <= cfg_wr_data;

			if ((state_q == ST_CHECK && !started_q) ||
			    (state_q == ST_DECIDE && outside)) begin
				anchor_value_q <= v_q;
				anchor_time_q  <= t_q;
				upper_q        <= DOOR_UP;
				lower_q        <= DOOR_LO;
				started_q      <= 1'b1;
			end else if (state_q == ST_DECIDE) begin
				if (nu < upper_q) upper_q <= nu;
				if (nl > lower_q) lower_q <= nl;
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// per-transaction working registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && sample_valid) begin
			v_q <= v_sat;
			t_q <= sample.sample_time;
		end
		if (state_q == ST_CHECK) begin
			dt_q <= dt_full[DT_W-1:0];
			if (!started_q) begin
				res_q.archive  <= 1'b1;
				res_q.decision <= DEC_FIRST;
			end else begin
				res_q.archive  <= 1'b0;
				res_q.decision <= DEC_NO_PROGRESS;
			end
		end
		if (state_q == ST_DIV_A && div_done) begin
			fa_q <= div_floor;
			ca_q <= div_ceil;
		end
		if (state_q == ST_DIV_B && div_done) begin
			fb_q <= div_floor;
			cb_q <= div_ceil;
		end
		if (state_q == ST_DECIDE) begin
			res_q.archive  <= outside;
			res_q.decision <= outside ? DEC_OUTSIDE : DEC_INSIDE;
		end
		if (load_out) out_q <= res_q;
	end

	assign sample_stall = (state_q != ST_IDLE);
	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule
